// File: sv/lrhg_pkg.sv
// Package for the lidar radial height gate.
// Holds the configuration register indexes, the zone codes and the register bundle type.
// No dependencies.
package lrhg_pkg;

  localparam int unsigned RADIUS_W   = 15;
  localparam int unsigned HEIGHT_W   = 16;
  localparam int unsigned RSQ_W      = 2 * RADIUS_W;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INNER_RADIUS = 4'd0,
    CFG_FLAT_RADIUS  = 4'd1,
    CFG_RING1_RADIUS = 4'd2,
    CFG_RING2_RADIUS = 4'd3,
    CFG_START_HEIGHT = 4'd4,
    CFG_MAX_HEIGHT   = 4'd5,
    CFG_TIER_CAPS    = 4'd6,
    CFG_SLOPE_SET    = 4'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ZONE_INNER = 3'd0,
    ZONE_FLAT  = 3'd1,
    ZONE_RING1 = 3'd2,
    ZONE_RING2 = 3'd3,
    ZONE_OUTER = 3'd4
  } zone_e;

  localparam int unsigned ZONE_W = 3;

  typedef struct packed {
    logic        [RSQ_W-1:0]    inner_sq;
    logic        [RSQ_W-1:0]    flat_sq;
    logic        [RSQ_W-1:0]    ring1_sq;
    logic        [RSQ_W-1:0]    ring2_sq;
    logic        [RADIUS_W-1:0] flat_r;
    logic        [RADIUS_W-1:0] ring1_r;
    logic        [RADIUS_W-1:0] ring2_r;
    logic signed [HEIGHT_W-1:0] start_h;
    logic signed [HEIGHT_W-1:0] max_h;
    logic signed [HEIGHT_W-1:0] cap2;
    logic signed [HEIGHT_W-1:0] cap3;
    logic signed [HEIGHT_W-1:0] slope1;
    logic signed [HEIGHT_W-1:0] slope2;
    logic signed [HEIGHT_W-1:0] slope3;
  } cfg_t;

endpackage

// File: sv/lidar_radial_height_gate_top.sv
// Lidar radial height gate: keeps or drops one point per item and echoes it.
// Throughput: one item per cycle; the square root chain has one cell per root bit.
// The whole pipeline holds while the output item waits; input ready follows that.
// Reset (rst_ni low, asynchronous) clears all valid bits and all config registers to 0.
// Depends on lrhg_pkg, lrhg_cfg_regs and lrhg_sqrt_cell.
module lidar_radial_height_gate_top #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // tdata: point_x, point_y, point_height, point_z
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // tdata: out_x, out_y, out_z; tuser: keep
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((3*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
  output logic [0:0]                             m_axis_tuser,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [lrhg_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [lrhg_pkg::CFG_DATA_W-1:0]         cfg_data_i
);
  import lrhg_pkg::*;

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned OUT_W = ((3 * CB + 7) / 8) * 8;
  localparam int unsigned R2W   = 2 * CB;
  localparam int unsigned CMPW  = (R2W > RSQ_W) ? R2W : RSQ_W;
  localparam int unsigned SW    = 4 * CB + ZONE_W;
  localparam int unsigned DW    = ((CB > RADIUS_W) ? CB : RADIUS_W) + 2;
  localparam int unsigned PW    = DW + HEIGHT_W;
  localparam int unsigned LW    = PW + 1;

  cfg_t cfg;
  logic adv;

  lrhg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // stage 1: squares
  logic [CB-1:0]  in_x, in_y, in_h, in_z, ux, uy;
  logic           v1_q;
  logic [CB-1:0]  x1_q, y1_q, h1_q, z1_q;
  logic [R2W-1:0] sqx1_q, sqy1_q;

  assign in_x = s_axis_tdata[CB-1:0];
  assign in_y = s_axis_tdata[2*CB-1:CB];
  assign in_h = s_axis_tdata[3*CB-1:2*CB];
  assign in_z = s_axis_tdata[4*CB-1:3*CB];
  assign ux   = in_x[CB-1] ? (~in_x + CB'(1)) : in_x;
  assign uy   = in_y[CB-1] ? (~in_y + CB'(1)) : in_y;

  // stage 2: squared range
  logic           v2_q;
  logic [CB-1:0]  x2_q, y2_q, h2_q, z2_q;
  logic [R2W-1:0] r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_q   <= in_x;
      y1_q   <= in_y;
      h1_q   <= in_h;
      z1_q   <= in_z;
      sqx1_q <= ux * ux;
      sqy1_q <= uy * uy;
      x2_q   <= x1_q;
      y2_q   <= y1_q;
      h2_q   <= h1_q;
      z2_q   <= z1_q;
      r2_q   <= sqx1_q + sqy1_q;
    end
  end

  // zone selection in fixed order
  logic [CMPW-1:0] r2_e;
  zone_e           zone2;

  assign r2_e = CMPW'(r2_q);

  always_comb begin
    priority if (r2_e <= CMPW'(cfg.inner_sq)) zone2 = ZONE_INNER;
    else if (r2_e <= CMPW'(cfg.flat_sq))      zone2 = ZONE_FLAT;
    else if (r2_e <= CMPW'(cfg.ring1_sq))     zone2 = ZONE_RING1;
    else if (r2_e <= CMPW'(cfg.ring2_sq))     zone2 = ZONE_RING2;
    else                                      zone2 = ZONE_OUTER;
  end

  // square root chain
  logic           vc   [CB+1];
  logic [R2W-1:0] remc [CB+1];
  logic [CB-1:0]  rootc[CB+1];
  logic [SW-1:0]  sidec[CB+1];

  assign vc[0]    = v2_q;
  assign remc[0]  = r2_q;
  assign rootc[0] = '0;
  assign sidec[0] = {zone2, z2_q, h2_q, y2_q, x2_q};

  for (genvar k = 0; k < CB; k++) begin : g_cell
    lrhg_sqrt_cell #(
      .R2W (R2W),
      .RW  (CB),
      .BIT (CB - 1 - k),
      .SW  (SW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (vc[k]),
      .rem_i   (remc[k]),
      .root_i  (rootc[k]),
      .side_i  (sidec[k]),
      .valid_o (vc[k+1]),
      .rem_o   (remc[k+1]),
      .root_o  (rootc[k+1]),
      .side_o  (sidec[k+1])
    );
  end

  // multiply stage: pick ring parameters, form d * slope
  logic [SW-1:0]              side_c;
  zone_e                      zone_c;
  logic [RADIUS_W-1:0]        start_r;
  logic signed [HEIGHT_W-1:0] slope_c, base_c, cap_c;
  logic signed [DW-1:0]       dist_c;
  logic signed [PW-1:0]       prod_d;

  assign side_c = sidec[CB];
  assign zone_c = zone_e'(side_c[SW-1:4*CB]);

  always_comb begin
    unique case (zone_c)
      ZONE_RING1: begin
        start_r = cfg.flat_r;
        slope_c = cfg.slope1;
        base_c  = cfg.start_h;
        cap_c   = cfg.max_h;
      end
      ZONE_RING2: begin
        start_r = cfg.ring1_r;
        slope_c = cfg.slope2;
        base_c  = cfg.max_h;
        cap_c   = cfg.cap2;
      end
      ZONE_OUTER: begin
        start_r = cfg.ring2_r;
        slope_c = cfg.slope3;
        base_c  = cfg.cap2;
        cap_c   = cfg.cap3;
      end
      default: begin
        start_r = '0;
        slope_c = '0;
        base_c  = cfg.start_h;
        cap_c   = '0;
      end
    endcase
  end

  assign dist_c = $signed(DW'(rootc[CB]) - DW'(start_r));
  assign prod_d = dist_c * slope_c;

  logic                       vm_q;
  zone_e                      zonem_q;
  logic [CB-1:0]              xm_q, ym_q, hm_q, zm_q;
  logic signed [PW-1:0]       prodm_q;
  logic signed [HEIGHT_W-1:0] basem_q, capm_q;

  // output stage: height test
  logic signed [LW-1:0] hq, lim;
  logic                 keep_d;

  assign hq  = {{(LW-CB-8){hm_q[CB-1]}}, hm_q, 8'b0};
  assign lim = {prodm_q[PW-1], prodm_q} + {{(LW-HEIGHT_W-8){basem_q[HEIGHT_W-1]}}, basem_q, 8'b0};

  always_comb begin
    unique case (zonem_q)
      ZONE_INNER: keep_d = 1'b0;
      ZONE_FLAT:  keep_d = $signed(hm_q) <= basem_q;
      default:    keep_d = (hq <= lim) && ($signed(hm_q) <= capm_q);
    endcase
  end

  logic          vo_q;
  logic          keep_q;
  logic [CB-1:0] xo_q, yo_q, zo_q;

  assign adv = !vo_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      vm_q <= vc[CB];
      vo_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zonem_q <= zone_c;
      xm_q    <= side_c[CB-1:0];
      ym_q    <= side_c[2*CB-1:CB];
      hm_q    <= side_c[3*CB-1:2*CB];
      zm_q    <= side_c[4*CB-1:3*CB];
      prodm_q <= prod_d;
      basem_q <= base_c;
      capm_q  <= cap_c;
      keep_q  <= keep_d;
      xo_q    <= xm_q;
      yo_q    <= ym_q;
      zo_q    <= zm_q;
    end
  end

  assign s_axis_tready = adv;
  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = OUT_W'({zo_q, yo_q, xo_q});
  assign m_axis_tuser  = keep_q;

endmodule

// File: sv/lrhg_cfg_regs.sv
// Configuration registers of the lidar radial height gate.
// Squares each radius once on write. Depends on lrhg_pkg.
module lrhg_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lrhg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lrhg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output lrhg_pkg::cfg_t                 cfg_o
);
  import lrhg_pkg::*;

  cfg_t              cfg_q, cfg_d;
  logic [RADIUS_W-1:0] wr_r;
  logic [RSQ_W-1:0]    wr_sq;

  assign cfg_ready_o = 1'b1;
  assign wr_r        = cfg_data_i[RADIUS_W-1:0];
  assign wr_sq       = wr_r * wr_r;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_INNER_RADIUS: cfg_d.inner_sq = wr_sq;
        CFG_FLAT_RADIUS: begin
          cfg_d.flat_sq = wr_sq;
          cfg_d.flat_r  = wr_r;
        end
        CFG_RING1_RADIUS: begin
          cfg_d.ring1_sq = wr_sq;
          cfg_d.ring1_r  = wr_r;
        end
        CFG_RING2_RADIUS: begin
          cfg_d.ring2_sq = wr_sq;
          cfg_d.ring2_r  = wr_r;
        end
        CFG_START_HEIGHT: cfg_d.start_h = cfg_data_i[15:0];
        CFG_MAX_HEIGHT:   cfg_d.max_h   = cfg_data_i[15:0];
        CFG_TIER_CAPS: begin
          cfg_d.cap2 = cfg_data_i[15:0];
          cfg_d.cap3 = cfg_data_i[31:16];
        end
        CFG_SLOPE_SET: begin
          cfg_d.slope1 = cfg_data_i[15:0];
          cfg_d.slope2 = cfg_data_i[31:16];
          cfg_d.slope3 = cfg_data_i[47:32];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/lrhg_sqrt_cell.sv
// One cell of the integer square root chain: resolves one root bit per item.
// Carries the item's sideband to the next cell. No package dependency.
module lrhg_sqrt_cell #(
  parameter int unsigned R2W = 32,
  parameter int unsigned RW  = 16,
  parameter int unsigned BIT = 15,
  parameter int unsigned SW  = 67
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [R2W-1:0] rem_i,
  input  logic [RW-1:0]  root_i,
  input  logic [SW-1:0]  side_i,
  output logic           valid_o,
  output logic [R2W-1:0] rem_o,
  output logic [RW-1:0]  root_o,
  output logic [SW-1:0]  side_o
);

  logic [R2W-1:0] trial;
  logic           fits;
  logic           valid_q;
  logic [R2W-1:0] rem_q, rem_d;
  logic [RW-1:0]  root_q, root_d;
  logic [SW-1:0]  side_q;

  assign trial  = (R2W'(root_i) << (BIT + 1)) | (R2W'(1) << (2 * BIT));
  assign fits   = rem_i >= trial;
  assign rem_d  = fits ? rem_i - trial : rem_i;
  assign root_d = fits ? (root_i | (RW'(1) << BIT)) : root_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

// File: sv/lrhg_checker.sv
// Port-level checks for the lidar radial height gate.
// Bound to lidar_radial_height_gate_top; depends on nothing else.
module lrhg_checker #(
  parameter int unsigned OUT_W = 48
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic [0:0]       m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input held off with empty output");

  a_ready_when_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input held off while output drains");

endmodule

bind lidar_radial_height_gate_top lrhg_checker #(
  .OUT_W (OUT_W)
) u_lrhg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// File: tb/sv/tb_top.sv
// Self-checking testbench for lidar_radial_height_gate_top: streams points under
// several gate settings and idle patterns, predicts keep and echo per point.
// Depends on lrhg_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
  import lrhg_pkg::*;

  localparam int unsigned CB = 16;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam longint DROPPED_Q8 = -(longint'(1) << 40);

  typedef struct packed {
    logic        keep;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } gate_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  lidar_radial_height_gate_top #(.COORD_BITS(CB)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  logic [14:0]        gate_inner = '0;
  logic [14:0]        gate_flat = '0;
  logic [14:0]        gate_ring1 = '0;
  logic [14:0]        gate_ring2 = '0;
  logic signed [15:0] gate_start_h = '0;
  logic signed [15:0] gate_max_h = '0;
  logic [31:0]        gate_caps = '0;
  logic [47:0]        gate_slopes = '0;

  logic [63:0]  points_to_send[$];
  gate_result_t pending_verdicts[$];
  int unsigned  src_idle_pct = 0;
  int unsigned  snk_stall_pct = 0;
  int unsigned  mismatches = 0;
  int unsigned  points_accepted = 0;
  int unsigned  results_seen = 0;
  int unsigned  reg_writes = 0;
  int unsigned  settings_used = 0;
  int unsigned  quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint int_root(longint n);
    longint root;
    longint trial;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic longint ring_limit_q8(longint d, longint slope, longint base,
                                           longint cap);
    longint lim;
    lim = d * slope + base * 256;
    if (cap * 256 < lim) lim = cap * 256;
    return lim;
  endfunction

  // Height limit scaled by 256 for a point; a huge negative value means dropped.
  function automatic longint gate_limit_q8(logic signed [15:0] px, logic signed [15:0] py);
    longint ax, ay, r2, root, hs, hm, c2, c3, s1, s2, s3;
    ax = px;
    ay = py;
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    r2 = ax * ax + ay * ay;
    root = int_root(r2);
    hs = gate_start_h;
    hm = gate_max_h;
    c2 = $signed(gate_caps[15:0]);
    c3 = $signed(gate_caps[31:16]);
    s1 = $signed(gate_slopes[15:0]);
    s2 = $signed(gate_slopes[31:16]);
    s3 = $signed(gate_slopes[47:32]);
    if (r2 <= longint'(gate_inner) * longint'(gate_inner)) return DROPPED_Q8;
    if (r2 <= longint'(gate_flat) * longint'(gate_flat)) return hs * 256;
    if (r2 <= longint'(gate_ring1) * longint'(gate_ring1))
      return ring_limit_q8(root - longint'(gate_flat), s1, hs, hm);
    if (r2 <= longint'(gate_ring2) * longint'(gate_ring2))
      return ring_limit_q8(root - longint'(gate_ring1), s2, hm, c2);
    return ring_limit_q8(root - longint'(gate_ring2), s3, c2, c3);
  endfunction

  function automatic gate_result_t predict_gate(logic [63:0] pt);
    gate_result_t res;
    logic signed [15:0] h;
    h = pt[47:32];
    res.keep = (longint'(h) * 256 <= gate_limit_q8(pt[15:0], pt[31:16]));
    res.x = pt[15:0];
    res.y = pt[31:16];
    res.z = pt[63:48];
    return res;
  endfunction

  function automatic logic [63:0] pack_point(longint x, longint y, longint h, longint z);
    logic [15:0] fx, fy, fh, fz;
    fx = x[15:0];
    fy = y[15:0];
    fh = h[15:0];
    fz = z[15:0];
    return {fz, fh, fy, fx};
  endfunction

  task automatic enqueue_point(logic [63:0] pt);
    points_to_send.insert(points_to_send.size(), pt);
  endtask

  function automatic logic [63:0] random_point();
    int unsigned pick;
    longint x, y, h, r, t;
    logic [31:0] raw;
    pick = $urandom_range(9);
    raw = $urandom;
    if (pick < 2) begin
      x = $signed(raw[15:0]);
      y = $signed(raw[31:16]);
    end else if (pick < 8) begin
      case ($urandom_range(3))
        0: r = gate_inner;
        1: r = gate_flat;
        2: r = gate_ring1;
        default: r = gate_ring2;
      endcase
      r = clamp(r + $urandom_range(6) - 3, 0, 32767);
      if ($urandom_range(1)) begin
        x = r;
        y = $urandom_range(4);
      end else begin
        x = (r * 181) >>> 8;
        y = x + $urandom_range(2) - 1;
      end
      if ($urandom_range(1)) x = -x;
      if ($urandom_range(1)) y = -y;
      if ($urandom_range(1)) begin
        t = x;
        x = y;
        y = t;
      end
    end else begin
      x = longint'($urandom_range(2048)) - 1024;
      y = longint'($urandom_range(2048)) - 1024;
    end
    x = clamp(x, -32768, 32767);
    y = clamp(y, -32768, 32767);
    pick = $urandom_range(9);
    raw = $urandom;
    if (pick < 6)
      h = (gate_limit_q8(x[15:0], y[15:0]) >>> 8) + longint'($urandom_range(4)) - 2;
    else if (pick < 8) h = $signed(raw[15:0]);
    else h = longint'($urandom_range(4000)) - 2000;
    h = clamp(h, -32768, 32767);
    return pack_point(x, y, h, $signed(raw[31:16]));
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_verdicts.insert(pending_verdicts.size(), predict_gate(s_axis_tdata));
        points_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (points_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= points_to_send.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string what, gate_result_t want, gate_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: want keep=%0d x=%0d y=%0d z=%0d, got keep=%0d x=%0d y=%0d z=%0d",
               what, want.keep, $signed(want.x), $signed(want.y), $signed(want.z),
               got.keep, $signed(got.x), $signed(got.y), $signed(got.z));
  endtask

  always @(posedge clk_i) begin
    gate_result_t got;
    gate_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        got.keep = m_axis_tuser[0];
        got.x = m_axis_tdata[15:0];
        got.y = m_axis_tdata[31:16];
        got.z = m_axis_tdata[47:32];
        if (pending_verdicts.size() == 0) begin
          report_mismatch("unexpected item", '0, got);
        end else begin
          want = pending_verdicts.pop_front();
          if (got.keep !== want.keep || got.x !== want.x || got.y !== want.y ||
              got.z !== want.z)
            report_mismatch("mismatch", want, got);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d cycles without progress", quiet_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_INNER_RADIUS: gate_inner = val[14:0];
      CFG_FLAT_RADIUS:  gate_flat = val[14:0];
      CFG_RING1_RADIUS: gate_ring1 = val[14:0];
      CFG_RING2_RADIUS: gate_ring2 = val[14:0];
      CFG_START_HEIGHT: gate_start_h = val[15:0];
      CFG_MAX_HEIGHT:   gate_max_h = val[15:0];
      CFG_TIER_CAPS:    gate_caps = val[31:0];
      CFG_SLOPE_SET:    gate_slopes = val[47:0];
      default: ;
    endcase
  endtask

  // Upper bits beyond each register's width carry junk that must be masked.
  task automatic program_gate(longint ri, longint rf, longint r1, longint r2, longint hs,
                              longint hm, logic [31:0] caps, logic [47:0] slopes);
    logic [47:0] junk;
    junk = 48'({$urandom, $urandom});
    write_reg(CFG_INNER_RADIUS, {junk[47:15], ri[14:0]});
    write_reg(CFG_FLAT_RADIUS, {junk[32:0], rf[14:0]});
    write_reg(CFG_RING1_RADIUS, {junk[40:8], r1[14:0]});
    write_reg(CFG_RING2_RADIUS, {junk[45:13], r2[14:0]});
    write_reg(CFG_START_HEIGHT, {junk[47:16], hs[15:0]});
    write_reg(CFG_MAX_HEIGHT, {junk[31:0], hm[15:0]});
    write_reg(CFG_TIER_CAPS, {junk[15:0], caps});
    write_reg(CFG_SLOPE_SET, slopes);
    write_reg(4'($urandom_range(15, 8)), junk);
    settings_used++;
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (points_to_send.size() != 0 || s_axis_tvalid || pending_verdicts.size() != 0);
  endtask

  function automatic logic [15:0] random_height();
    logic [31:0] raw;
    raw = $urandom;
    if (raw[31]) return raw[15:0];
    return 16'(longint'($urandom_range(4000)) - 2000);
  endfunction

  function automatic logic [15:0] random_slope();
    logic [31:0] raw;
    raw = $urandom;
    if (raw[31:30] == 2'b00) return raw[15:0];
    if (raw[31:30] == 2'b01) return {raw[16], 7'd0, 8'd0} | {8'd0, raw[7:0]};
    return 16'(longint'($urandom_range(1024)) - 512);
  endfunction

  initial begin
    longint ri, rf, r1, r2;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: only the origin is dropped, elsewhere keep at or below zero
    enqueue_point(pack_point(0, 0, -5, 7));
    enqueue_point(pack_point(1, 0, 0, -1));
    enqueue_point(pack_point(-300, 400, 1, 12));
    enqueue_point(pack_point(32767, -32768, -32768, 32767));
    drain();

    program_gate(500, 2000, 6000, 12000, 300, 1500, {16'd3000, 16'd2500},
                 {16'hFFC0, 16'h0040, 16'h0080});
    enqueue_point(pack_point(500, 0, -32768, 1));
    enqueue_point(pack_point(0, -501, -32768, 2));
    enqueue_point(pack_point(-2000, 0, 300, 3));
    enqueue_point(pack_point(0, 2000, 301, 4));
    enqueue_point(pack_point(3000, 0, 800, 5));
    enqueue_point(pack_point(1800, -2400, 801, 6));
    enqueue_point(pack_point(2001, 0, 300, 7));
    enqueue_point(pack_point(6000, 0, 1500, 8));
    enqueue_point(pack_point(0, -6000, 1501, 9));
    enqueue_point(pack_point(9000, 0, 2250, 10));
    enqueue_point(pack_point(-9000, 0, 2251, 11));
    enqueue_point(pack_point(20000, 0, 500, 12));
    enqueue_point(pack_point(0, 20000, 501, 13));
    enqueue_point(pack_point(1000, 1000, 1000, 14));
    enqueue_point(pack_point(32767, 32767, 32767, 32767));
    enqueue_point(pack_point(-32768, -32768, -32768, -32768));
    enqueue_point(pack_point(-32768, 32767, 0, 0));
    enqueue_point(pack_point(21845, -10923, -21846, 10922));
    drain();

    // misordered radii: ring one test never sees a negative distance
    program_gate(100, 4000, 1000, 30000, -200, 700, {16'h8000, 16'h7FFF},
                 {16'h8000, 16'h7FFF, 16'h0100});
    enqueue_point(pack_point(2500, 0, -200, 21));
    enqueue_point(pack_point(5000, 0, 32767, 22));
    drain();

    for (int k = 0; k < 10; k++) begin
      if (k == 2) begin
        program_gate(32767, 32767, 32767, 32767, 32767, 32767, 32'h7FFF7FFF,
                     48'h7FFF7FFF7FFF);
      end else if (k == 5) begin
        program_gate(0, 0, 0, 0, -32768, -32768, 32'h80008000, 48'h800080008000);
      end else if (k % 3 == 1) begin
        program_gate($urandom_range(32767), $urandom_range(32767), $urandom_range(32767),
                     $urandom_range(32767), $signed(random_height()),
                     $signed(random_height()), {random_height(), random_height()},
                     {random_slope(), random_slope(), random_slope()});
      end else begin
        ri = $urandom_range(3000);
        rf = ri + $urandom_range(5000);
        r1 = rf + $urandom_range(8000);
        r2 = r1 + $urandom_range(8000);
        program_gate(ri, rf, r1, r2, $signed(random_height()), $signed(random_height()),
                     {random_height(), random_height()},
                     {random_slope(), random_slope(), random_slope()});
      end
      case (k % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 57; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 57; end
        default: begin src_idle_pct = 27; snk_stall_pct = 27; end
      endcase
      for (int i = 0; i < 66; i++) enqueue_point(random_point());
      drain();
    end

    repeat (30) @(posedge clk_i);
    if (pending_verdicts.size() != 0) begin
      $display("%0d points never produced an item", pending_verdicts.size());
      mismatches += pending_verdicts.size();
    end
    $display("covered %0d points under %0d gate settings with %0d register writes,",
             points_accepted, settings_used, reg_writes);
    $display("checked %0d output items, %0d failures", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
